/* rtl/kcl_pkg.sv */
// Package for the knob code lock: shared types, register indexes and reset values.
// Used by every module of the block; depends on nothing.
package kcl_pkg;

  // Build-time defaults
  localparam int CODE_LENGTH_DEF = 4;
  localparam int DIGIT_SHIFT_DEF = 4;

  // Field widths
  localparam int SAMPLE_W  = 10;
  localparam int DIGIT_W   = 6;
  localparam int CODE_W    = 24;
  localparam int HOLD_W    = 8;
  localparam int TIMEOUT_W = 16;
  localparam int INDEX_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int S_DATA_W  = 16;
  localparam int M_DATA_W  = 8;

  // Register reset values (digits 0,4,3,6)
  localparam logic [CODE_W-1:0]    CODE_WORD_RST     = 24'd1585408;
  localparam logic [HOLD_W-1:0]    HOLD_TICKS_RST    = 8'd220;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 16'd2200;

  // Register indexes on the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_WORD     = 2'd0,
    REG_HOLD_TICKS    = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2
  } kcl_reg_t;

  // Configuration as seen by the entry logic
  typedef struct packed {
    logic [CODE_W-1:0]    code_word;
    logic [HOLD_W-1:0]    hold_ticks;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } kcl_cfg_t;

  // One result item
  typedef struct packed {
    logic               entry_failed;
    logic               unlock_pulse;
    logic [INDEX_W-1:0] digits_entered;
    logic               digit_accepted;
    logic               knob_moved;
  } kcl_result_t;

endpackage

/* rtl/kcl_entry.sv */
// Entry state of the knob code lock: digit tracking, hold counter, digit count, timeout.
// Steps once per advanced request; depends on kcl_pkg.
module kcl_entry #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF,
  parameter int DIGIT_SHIFT = kcl_pkg::DIGIT_SHIFT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [kcl_pkg::SAMPLE_W-1:0]  sample,
  input  kcl_pkg::kcl_cfg_t             cfg,
  output kcl_pkg::kcl_result_t          result
);

  logic [kcl_pkg::DIGIT_W-1:0]   last_digit, last_digit_next;
  logic                          armed, armed_next;
  logic [kcl_pkg::HOLD_W-1:0]    hold_count, hold_count_next;
  logic [kcl_pkg::INDEX_W-1:0]   digit_index, digit_index_next;
  logic [kcl_pkg::TIMEOUT_W-1:0] time_left, time_left_next;

  logic [kcl_pkg::SAMPLE_W-1:0]  shifted;
  logic [kcl_pkg::DIGIT_W-1:0]   digit;
  logic [kcl_pkg::DIGIT_W-1:0]   code_digit;
  logic [kcl_pkg::INDEX_W-1:0]   index_inc;
  logic [kcl_pkg::TIMEOUT_W-1:0] time_dec;
  logic                          moved, accepted, unlocked, failed;

  // Quantize the sample; only the low digit bits are kept
  assign shifted = sample >> DIGIT_SHIFT;
  assign digit   = shifted[kcl_pkg::DIGIT_W-1:0];
  assign moved   = (digit != last_digit);

  // Expected digit for the current position (position taken mod 4)
  always_comb begin
    case (digit_index[1:0])
      2'd0:    code_digit = cfg.code_word[5:0];
      2'd1:    code_digit = cfg.code_word[11:6];
      2'd2:    code_digit = cfg.code_word[17:12];
      default: code_digit = cfg.code_word[23:18];
    endcase
  end

  assign index_inc = digit_index + 3'd1;

  // Next state for one tick
  always_comb begin
    last_digit_next  = digit;
    armed_next       = armed;
    hold_count_next  = hold_count;
    digit_index_next = digit_index;
    time_left_next   = time_left;
    accepted         = 1'b0;
    unlocked         = 1'b0;
    failed           = 1'b0;

    if (moved) begin
      hold_count_next = '0;
      armed_next      = 1'b1;
    end else if (armed) begin
      if (hold_count == cfg.hold_ticks) begin
        // held long enough: judge the digit, a wrong one changes nothing
        if (digit == code_digit) begin
          accepted         = 1'b1;
          time_left_next   = cfg.timeout_ticks;
          digit_index_next = index_inc;
          armed_next       = 1'b0;
          if (index_inc >= kcl_pkg::INDEX_W'(CODE_LENGTH)) begin
            unlocked         = 1'b1;
            digit_index_next = '0;
            time_left_next   = '0;
            hold_count_next  = '0;
          end
        end
      end else begin
        hold_count_next = hold_count + 8'd1;
      end
    end

    // Countdown runs after any reload in the same tick
    time_dec = time_left_next - 16'd1;
    if (time_left_next != '0) begin
      time_left_next = time_dec;
      if (time_dec == '0) begin
        failed           = 1'b1;
        digit_index_next = '0;
        hold_count_next  = '0;
        armed_next       = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_digit  <= '0;
      armed       <= 1'b0;
      hold_count  <= '0;
      digit_index <= '0;
      time_left   <= '0;
    end else if (step) begin
      last_digit  <= last_digit_next;
      armed       <= armed_next;
      hold_count  <= hold_count_next;
      digit_index <= digit_index_next;
      time_left   <= time_left_next;
    end
  end

  assign result.knob_moved     = moved;
  assign result.digit_accepted = accepted;
  assign result.digits_entered = digit_index_next;
  assign result.unlock_pulse   = unlocked;
  assign result.entry_failed   = failed;

endmodule

/* rtl/knob_code_lock_unit.sv */
// Top level of the knob code lock: config registers, input register, result register.
// Depends on kcl_pkg and kcl_entry.

// Knob code lock. One request on the s side is one tick carrying a 10-bit knob
// sample; each tick gives exactly one result on the m side, in order. A request
// passes an input register, one step of the entry logic and a result register;
// one request can be taken every cycle while m_tready keeps the output free, and
// the two registers let a new request enter while a finished result waits on m_tready.
// The user must write configuration through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this. Reset restores the code
// 0,4,3,6, a hold of 220 ticks and a timeout of 2200 ticks.
module knob_code_lock_unit #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF,
  parameter int DIGIT_SHIFT = kcl_pkg::DIGIT_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [kcl_pkg::S_DATA_W-1:0]   s_tdata,   // [9:0] adc_sample
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [kcl_pkg::M_DATA_W-1:0]   m_tdata,   // [0] knob_moved, [1] digit_accepted,
                                                    // [4:2] digits_entered,
                                                    // [5] unlock_pulse, [6] entry_failed
  // configuration writes
  input  logic                           cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data
);

  kcl_pkg::kcl_cfg_t    cfg;
  kcl_pkg::kcl_result_t step_result;
  kcl_pkg::kcl_result_t out_result;

  logic                          in_valid;
  logic [kcl_pkg::SAMPLE_W-1:0]  in_sample;
  logic                          out_free;
  logic                          advance;

  // Configuration registers; unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_word     <= kcl_pkg::CODE_WORD_RST;
      cfg.hold_ticks    <= kcl_pkg::HOLD_TICKS_RST;
      cfg.timeout_ticks <= kcl_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kcl_pkg::REG_CODE_WORD:     cfg.code_word     <= cfg_data;
        kcl_pkg::REG_HOLD_TICKS:    cfg.hold_ticks    <= cfg_data[kcl_pkg::HOLD_W-1:0];
        kcl_pkg::REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data[kcl_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= s_tdata[kcl_pkg::SAMPLE_W-1:0];
    end
  end

  kcl_entry #(
    .CODE_LENGTH (CODE_LENGTH),
    .DIGIT_SHIFT (DIGIT_SHIFT)
  ) u_entry (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .sample (in_sample),
    .cfg    (cfg),
    .result (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {1'b0, out_result};

endmodule

/* rtl/kcl_checker.sv */
// Port-level checks for the knob code lock, bound to knob_code_lock_unit.
// Depends on kcl_pkg and the top level's ports.
module kcl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [kcl_pkg::M_DATA_W-1:0] m_tdata
);

  kcl_pkg::kcl_result_t res;
  assign res = m_tdata[kcl_pkg::M_DATA_W-2:0];

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Unlock only comes with an accepted digit and no failure, and leaves the count at zero
  a_unlock: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.unlock_pulse |->
      res.digit_accepted && res.digits_entered == '0 && !res.entry_failed)
    else $error("unlock without accepted digit or with nonzero count");

  // A failure clears the count
  a_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.entry_failed |-> res.digits_entered == '0)
    else $error("failure left digits entered");

  // An accepted digit that neither unlocks nor fails leaves a nonzero count
  a_accept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.digit_accepted && !res.unlock_pulse && !res.entry_failed |->
      res.digits_entered != '0)
    else $error("accepted digit without count");

endmodule

bind knob_code_lock_unit kcl_checker u_kcl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
